FILE: design/watchdog_timer_register_block_macros.svh
// Assertion helpers used by the checker module.
`ifndef WATCHDOG_TIMER_REGISTER_BLOCK_MACROS_SVH
`define WATCHDOG_TIMER_REGISTER_BLOCK_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define WDT_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("watchdog checker: same-cycle property failed");

// The consequent must hold in the cycle after the antecedent.
`define WDT_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("watchdog checker: next-cycle property failed");

// The consequent must hold in the cycle after reset is seen.
`define WDT_ASSERT_AFTER_RESET(label, cons) \
   label: assert property (@(posedge clock) reset |=> (cons)) \
      else $error("watchdog checker: post-reset property failed");

`endif

FILE: design/wdt_pkg.sv
package wdt_pkg;

   localparam int NUM_REGS  = 17;
   localparam int REG_IDX_W = $clog2(NUM_REGS);

   typedef logic [7:0] byte_type;

   typedef enum logic [1:0] {
      OP_READ  = 2'd0,
      OP_WRITE = 2'd1,
      OP_TICK  = 2'd2
   } op_type;

   localparam int IDX_RLD     = 0;
   localparam int IDX_TMR     = 1;
   localparam int IDX_DAT_IN  = 2;
   localparam int IDX_DAT_OUT = 3;
   localparam int IDX_STS1    = 4;
   localparam int IDX_STS1_HI = 5;
   localparam int IDX_STS2    = 6;
   localparam int IDX_STS2_HI = 7;
   localparam int IDX_CNT1    = 8;
   localparam int IDX_CNT1_HI = 9;
   localparam int IDX_CNT2    = 10;
   localparam int IDX_MSG1    = 12;
   localparam int IDX_MSG2    = 13;
   localparam int IDX_LAST    = 16;

   localparam byte_type OFF_RLD     = 8'(IDX_RLD);
   localparam byte_type OFF_TMR     = 8'(IDX_TMR);
   localparam byte_type OFF_DAT_IN  = 8'(IDX_DAT_IN);
   localparam byte_type OFF_DAT_OUT = 8'(IDX_DAT_OUT);
   localparam byte_type OFF_STS1    = 8'(IDX_STS1);
   localparam byte_type OFF_STS1_HI = 8'(IDX_STS1_HI);
   localparam byte_type OFF_STS2    = 8'(IDX_STS2);
   localparam byte_type OFF_STS2_HI = 8'(IDX_STS2_HI);
   localparam byte_type OFF_CNT1    = 8'(IDX_CNT1);
   localparam byte_type OFF_CNT1_HI = 8'(IDX_CNT1_HI);
   localparam byte_type OFF_CNT2    = 8'(IDX_CNT2);
   localparam byte_type OFF_MSG1    = 8'(IDX_MSG1);
   localparam byte_type OFF_MSG2    = 8'(IDX_MSG2);
   localparam byte_type OFF_LAST    = 8'(IDX_LAST);

   localparam byte_type COUNT_MASK    = 8'h3f;
   localparam byte_type MIN_COUNT     = 8'h04;
   localparam byte_type STS1_MASK     = 8'h7f;
   localparam byte_type STS1_HI_MASK  = 8'h1f;
   localparam byte_type STS2_MASK     = 8'h07;
   localparam byte_type CNT1_HI_MASK  = 8'h1f;
   localparam byte_type CNT2_MASK     = 8'h06;
   localparam byte_type LAST_MASK     = 8'h03;
   localparam byte_type DAT_IN_STS    = 8'h02;
   localparam byte_type DAT_OUT_STS   = 8'h04;
   localparam byte_type TIMEOUT_BIT   = 8'h08;
   localparam byte_type SECOND_BIT    = 8'h02;
   localparam byte_type OPEN_READ     = 8'hff;
   localparam int       NMI_NOW_POS   = 0;
   localparam int       HALT_POS      = 3;

   localparam int        CSR_ADDR_W     = 3;
   localparam int        CSR_DATA_W     = 32;
   localparam int        CSR_IDX_POS    = 2;
   localparam logic      CSR_IRQ_LINE   = 1'b0;
   localparam logic      CSR_SMI_ENABLE = 1'b1;
   localparam logic [3:0] IRQ_LINE_RESET = 4'd9;

   typedef struct packed {
      logic [1:0] op;
      byte_type   reg_offset;
      byte_type   write_data;
      logic       nmi_pending;
   } req_payload_type;

   typedef struct packed {
      byte_type read_data;
      logic     smi_pulse;
      logic     nmi_pulse;
      logic     irq_pulse;
      logic     second_timeout;
   } rsp_payload_type;

   function automatic byte_type reg_reset_value(input int idx);
      byte_type value;
      case (idx)
         IDX_RLD:     value = 8'h04;
         IDX_TMR:     value = 8'h04;
         IDX_CNT1_HI: value = TIMEOUT_BIT;
         IDX_LAST:    value = 8'h03;
         default:     value = 8'h00;
      endcase
      return value;
   endfunction

endpackage

FILE: design/wdt_req_if.sv
interface wdt_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] op;
   logic [7:0] reg_offset;
   logic [7:0] write_data;
   logic       nmi_pending;

   modport source (output valid, output op, output reg_offset, output write_data,
                   output nmi_pending, input ready);
   modport sink (input valid, input op, input reg_offset, input write_data,
                 input nmi_pending, output ready);
endinterface

FILE: design/wdt_rsp_if.sv
interface wdt_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] read_data;
   logic       smi_pulse;
   logic       nmi_pulse;
   logic       irq_pulse;
   logic       second_timeout;

   modport source (output valid, output read_data, output smi_pulse, output nmi_pulse,
                   output irq_pulse, output second_timeout, input ready);
   modport sink (input valid, input read_data, input smi_pulse, input nmi_pulse,
                 input irq_pulse, input second_timeout, output ready);
endinterface

FILE: design/wdt_core.sv
module wdt_core
   import wdt_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            take,
   input  req_payload_type item,
   input  logic            smi_enable,
   output rsp_payload_type result
);

   byte_type regs_ff [NUM_REGS];
   byte_type regs_in [NUM_REGS];
   logic     running_ff;
   logic     running_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_REGS; i++) begin
            regs_ff[i] <= reg_reset_value(i);
         end
         running_ff <= 1'b0;
      end else if (take) begin
         regs_ff    <= regs_in;
         running_ff <= running_in;
      end
   end

   always_comb begin
      logic [REG_IDX_W-1:0] off_idx;
      byte_type             init_count;
      byte_type             masked;
      byte_type             count_dec;
      logic                 halted;

      off_idx    = item.reg_offset[REG_IDX_W-1:0];
      init_count = regs_ff[IDX_TMR] & COUNT_MASK;
      halted     = regs_ff[IDX_CNT1_HI][HALT_POS];
      masked     = item.write_data & COUNT_MASK;
      count_dec  = regs_ff[IDX_RLD] - 8'(regs_ff[IDX_RLD] != 8'h00);

      regs_in    = regs_ff;
      running_in = running_ff;
      result     = '0;

      case (op_type'(item.op))
         OP_READ: begin
            result.read_data = (item.reg_offset <= OFF_LAST) ? regs_ff[off_idx] : OPEN_READ;
         end
         OP_WRITE: begin
            case (item.reg_offset)
               OFF_RLD: begin
                  regs_in[IDX_RLD] = init_count;
                  running_in       = !halted && (init_count != 8'h00);
               end
               OFF_TMR: begin
                  if (masked >= MIN_COUNT) begin
                     regs_in[IDX_TMR] = masked;
                  end
               end
               OFF_DAT_IN: begin
                  regs_in[IDX_DAT_IN] = item.write_data;
                  regs_in[IDX_STS1]   = regs_ff[IDX_STS1] | DAT_IN_STS;
                  result.smi_pulse    = 1'b1;
               end
               OFF_DAT_OUT: begin
                  regs_in[IDX_DAT_OUT] = item.write_data;
                  regs_in[IDX_STS1]    = regs_ff[IDX_STS1] | DAT_OUT_STS;
                  result.irq_pulse     = 1'b1;
               end
               OFF_STS1: begin
                  regs_in[IDX_STS1] = regs_ff[IDX_STS1] & ~(item.write_data & STS1_MASK);
               end
               OFF_STS1_HI: begin
                  regs_in[IDX_STS1_HI] = regs_ff[IDX_STS1_HI]
                                         & ~(item.write_data & STS1_HI_MASK);
               end
               OFF_STS2: begin
                  regs_in[IDX_STS2] = regs_ff[IDX_STS2] & ~(item.write_data & STS2_MASK);
               end
               OFF_STS2_HI: begin
                  regs_in[IDX_STS2_HI] = regs_ff[IDX_STS2_HI] & item.write_data;
               end
               OFF_CNT1, OFF_MSG1, OFF_MSG2: begin
                  regs_in[off_idx] = item.write_data;
               end
               OFF_CNT1_HI: begin
                  result.nmi_pulse     = item.write_data[NMI_NOW_POS] && !item.nmi_pending;
                  regs_in[IDX_CNT1_HI] = item.write_data & CNT1_HI_MASK;
                  running_in           = !item.write_data[HALT_POS] && (init_count != 8'h00);
               end
               OFF_CNT2: begin
                  regs_in[IDX_CNT2] = item.write_data & CNT2_MASK;
               end
               OFF_LAST: begin
                  regs_in[IDX_LAST] = item.write_data & LAST_MASK;
               end
               default: begin
               end
            endcase
         end
         OP_TICK: begin
            if (running_ff) begin
               if (halted) begin
                  running_in = 1'b0;
               end else if (count_dec != 8'h00) begin
                  regs_in[IDX_RLD] = count_dec;
                  running_in       = init_count != 8'h00;
               end else if ((regs_ff[IDX_STS1] & TIMEOUT_BIT) == 8'h00) begin
                  regs_in[IDX_STS1] = regs_ff[IDX_STS1] | TIMEOUT_BIT;
                  regs_in[IDX_RLD]  = init_count;
                  result.smi_pulse  = smi_enable;
                  running_in        = init_count != 8'h00;
               end else begin
                  regs_in[IDX_RLD]      = count_dec;
                  regs_in[IDX_STS2]     = regs_ff[IDX_STS2] | SECOND_BIT;
                  running_in            = 1'b0;
                  result.second_timeout = 1'b1;
               end
            end
         end
         default: begin
         end
      endcase
   end

endmodule

FILE: design/watchdog_timer_register_block.sv
// Watchdog register block: every request beat (register read, register write or timer tick)
// is taken and its response beat appears in the output register on the next cycle, so one
// beat per cycle is sustained while the response side is not stalled; each accepted beat
// does a read-modify-write of the 17-byte register file held in flip-flops. A waiting
// response beat does not block the next request unless the response side is stalled.
// The interrupt line and SMI enable are set through the CSR port at byte addresses 0 and 4.
module watchdog_timer_register_block
   import wdt_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   wdt_req_if.sink               req_bus,
   wdt_rsp_if.source             rsp_bus,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   logic [3:0]      irq_line_ff;
   logic [3:0]      irq_line_in;
   logic            smi_enable_ff;
   logic            smi_enable_in;
   logic            rsp_valid_ff;
   logic            rsp_valid_in;
   rsp_payload_type rsp_data_ff;
   rsp_payload_type core_result;
   req_payload_type req_item;
   logic            take;
   logic            csr_write;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      irq_line_in   = irq_line_ff;
      smi_enable_in = smi_enable_ff;
      if (csr_write) begin
         case (csr_paddr[CSR_IDX_POS])
            CSR_IRQ_LINE:   irq_line_in   = csr_pwdata[3:0];
            CSR_SMI_ENABLE: smi_enable_in = csr_pwdata[0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      case (csr_paddr[CSR_IDX_POS])
         CSR_IRQ_LINE:   csr_prdata = CSR_DATA_W'(irq_line_ff);
         CSR_SMI_ENABLE: csr_prdata = CSR_DATA_W'(smi_enable_ff);
         default:        csr_prdata = '0;
      endcase
   end

   assign req_bus.ready = !rsp_valid_ff || rsp_bus.ready;
   assign take          = req_bus.valid && req_bus.ready;

   assign req_item.op          = req_bus.op;
   assign req_item.reg_offset  = req_bus.reg_offset;
   assign req_item.write_data  = req_bus.write_data;
   assign req_item.nmi_pending = req_bus.nmi_pending;

   wdt_core u_core (
      .clock      (clock),
      .reset      (reset),
      .take       (take),
      .item       (req_item),
      .smi_enable (smi_enable_ff),
      .result     (core_result)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (take) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         irq_line_ff   <= IRQ_LINE_RESET;
         smi_enable_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         irq_line_ff   <= irq_line_in;
         smi_enable_ff <= smi_enable_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         rsp_data_ff <= core_result;
      end
   end

   assign rsp_bus.valid          = rsp_valid_ff;
   assign rsp_bus.read_data      = rsp_data_ff.read_data;
   assign rsp_bus.smi_pulse      = rsp_data_ff.smi_pulse;
   assign rsp_bus.nmi_pulse      = rsp_data_ff.nmi_pulse;
   assign rsp_bus.irq_pulse      = rsp_data_ff.irq_pulse;
   assign rsp_bus.second_timeout = rsp_data_ff.second_timeout;

endmodule

FILE: design/wdt_checker.sv
`include "watchdog_timer_register_block_macros.svh"

module wdt_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       req_nmi_pending,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] rsp_read_data,
   input logic       rsp_smi_pulse,
   input logic       rsp_nmi_pulse,
   input logic       rsp_irq_pulse,
   input logic       rsp_second_timeout
);

   // A stalled response beat keeps its contents.
   `WDT_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable({rsp_read_data, rsp_smi_pulse, rsp_nmi_pulse, rsp_irq_pulse, rsp_second_timeout}))

   // Reset empties the output register.
   `WDT_ASSERT_AFTER_RESET(a_rsp_empty_after_reset, !rsp_valid)

   // Every accepted request beat has its response beat on the following cycle.
   `WDT_ASSERT_NEXT(a_rsp_follows_req, req_valid && req_ready, rsp_valid)

   // Read data and interrupt pulses never come from the same beat.
   `WDT_ASSERT_NOW(a_read_no_pulse, rsp_valid && (rsp_read_data != 8'h00), !rsp_smi_pulse && !rsp_nmi_pulse && !rsp_irq_pulse && !rsp_second_timeout)

   // No NMI is raised while one is already pending.
   `WDT_ASSERT_NEXT(a_no_double_nmi, req_valid && req_ready && req_nmi_pending, !rsp_nmi_pulse)

endmodule

bind watchdog_timer_register_block wdt_checker u_checker (
   .clock              (clock),
   .reset              (reset),
   .req_valid          (req_bus.valid),
   .req_ready          (req_bus.ready),
   .req_nmi_pending    (req_bus.nmi_pending),
   .rsp_valid          (rsp_bus.valid),
   .rsp_ready          (rsp_bus.ready),
   .rsp_read_data      (rsp_bus.read_data),
   .rsp_smi_pulse      (rsp_bus.smi_pulse),
   .rsp_nmi_pulse      (rsp_bus.nmi_pulse),
   .rsp_irq_pulse      (rsp_bus.irq_pulse),
   .rsp_second_timeout (rsp_bus.second_timeout)
);
